/* hw/rtl/ukrt_pkg.sv */
// ============================================================================
// ukrt_pkg
// Shared types and constants for the unique key record table: request and
// response layouts, command and status codes, sequencer states.
// ============================================================================
package ukrt_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed result field widths
    localparam int MATCH_W  = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2,
        STAT_MISS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP_RD,
        ST_SWAP_WR
    } t_state;

    // One request
    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] plate_key;
        logic [15:0] make_code;
        logic [15:0] model_code;
        logic [15:0] colour_code;
    } t_req;

    // One response
    typedef struct packed {
        t_status              status;
        logic [MATCH_W-1:0]   match_index;
        logic [COUNT_W-1:0]   entry_count;
    } t_rsp;

    // One stored record
    typedef struct packed {
        logic [63:0] key;
        logic [15:0] make_code;
        logic [15:0] model_code;
        logic [15:0] colour_code;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Memory access from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             wsel_last;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // Compare results on the entry read last cycle
    typedef struct packed {
        logic key_hit;
        logic full_hit;
    } t_hit;

endpackage

/* hw/rtl/ukrt_ram.sv */
// ============================================================================
// ukrt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ============================================================================
module ukrt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ukrt_ctrl.sv */
// ============================================================================
// ukrt_ctrl
// Sequencer: scans the table one entry per cycle, decides the outcome, drives
// the memory writes for insert and swap-remove, and keeps the record count.
// ============================================================================
module ukrt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ukrt_pkg::t_cmd     i_cmd,
    input  ukrt_pkg::t_hit     i_hit,
    output ukrt_pkg::t_mem_req o_mem,
    output logic               o_busy,
    output logic               o_done,
    output ukrt_pkg::t_rsp     o_rsp
);
    import ukrt_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done, n_done;
    t_rsp             r_rsp, n_rsp;

    logic             accept;
    logic             sel_hit;
    logic             scan_hit;
    logic             scan_more;
    logic             scan_end;
    logic             table_full;
    logic [CNT_W-1:0] last_pos;

    assign o_busy    = (r_state != ST_IDLE);
    assign accept    = i_start && !o_busy;

    // Pick the compare that applies to the command
    always_comb begin
        unique case (i_cmd)
            CMD_INSERT: sel_hit = i_hit.key_hit;
            CMD_REMOVE: sel_hit = i_hit.full_hit;
            CMD_FIND:   sel_hit = i_hit.full_hit;
            default:    sel_hit = 1'b0;
        endcase
    end

    assign scan_hit   = r_rd_vld && sel_hit;
    assign scan_more  = (r_ptr < r_count);
    assign scan_end   = !r_rd_vld && !scan_more;
    assign table_full = (r_count == CNT_W'(CAPACITY));
    assign last_pos   = r_count - CNT_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_state = (i_cmd == CMD_REMOVE) ? ST_SWAP_RD : ST_IDLE;
                end else if (scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWAP_RD: n_state = ST_SWAP_WR;
            ST_SWAP_WR: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath control and response
    always_comb begin
        n_ptr             = r_ptr;
        n_rd_vld          = r_rd_vld;
        n_rd_idx          = r_rd_idx;
        n_slot            = r_slot;
        n_count           = r_count;
        n_done            = 1'b0;
        n_rsp             = r_rsp;
        o_mem.we          = 1'b0;
        o_mem.waddr       = r_count[IDX_W-1:0];
        o_mem.wsel_last   = 1'b0;
        o_mem.raddr       = r_ptr[IDX_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                // Start a fresh scan from slot zero
                if (accept) begin
                    n_ptr    = '0;
                    n_rd_vld = 1'b0;
                end
            end
            ST_SCAN: begin
                n_rsp.match_index = '0;
                if (scan_hit) begin
                    // First match found: finish, or go swap for remove
                    n_slot   = r_rd_idx;
                    n_rd_vld = 1'b0;
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            n_done       = 1'b1;
                            n_rsp.status = STAT_DUP;
                        end
                        CMD_FIND: begin
                            n_done            = 1'b1;
                            n_rsp.status      = STAT_OK;
                            n_rsp.match_index = MATCH_W'(r_rd_idx);
                        end
                        default: begin
                        end
                    endcase
                end else if (scan_more) begin
                    // Advance: read the next entry
                    n_ptr    = r_ptr + CNT_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[IDX_W-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                    if (scan_end) begin
                        n_done = 1'b1;
                        if (i_cmd == CMD_INSERT) begin
                            if (table_full) begin
                                n_rsp.status = STAT_FULL;
                            end else begin
                                o_mem.we     = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                                n_rsp.status = STAT_OK;
                            end
                        end else begin
                            n_rsp.status = STAT_MISS;
                        end
                    end
                end
            end
            ST_SWAP_RD: begin
                // Fetch the last record
                o_mem.raddr = last_pos[IDX_W-1:0];
            end
            ST_SWAP_WR: begin
                // Move the last record into the freed slot and shrink
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_slot;
                o_mem.wsel_last   = 1'b1;
                n_count           = last_pos;
                n_done            = 1'b1;
                n_rsp.status      = STAT_OK;
                n_rsp.match_index = '0;
            end
            default: begin
            end
        endcase

        n_rsp.entry_count = COUNT_W'(n_count);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_count  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_rd_vld <= n_rd_vld;
            r_count  <= n_count;
            r_done   <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_slot   <= n_slot;
        r_rsp    <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* hw/rtl/unique_key_record_table.sv */
// ============================================================================
// unique_key_record_table
// Fixed-capacity table of records (64-bit key, three 16-bit attribute codes)
// with insert, swap-remove and find.
// ============================================================================
// A request is taken when start is high and busy is low; busy then stays high
// until the response. The table is walked one entry per cycle through the
// record memory's single read port. A walk that runs to the end (insert,
// a remove or find that misses, the unused command code) reads all N held
// records; a match stops the walk early. A remove that hits then reads the
// last record and writes it into the freed slot. The response appears
// on o_rsp with o_done high for exactly one cycle, the cycle in which busy
// drops; the receiver cannot stall it, so it must capture the response in
// that cycle. A new request may be issued in that same cycle.
module unique_key_record_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ukrt_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output ukrt_pkg::t_rsp o_rsp
);
    import ukrt_pkg::*;

    t_req           r_req;
    t_mem_req       mem;
    t_hit           hit;
    t_entry         rd_entry;
    t_entry         req_entry;
    t_entry         wr_entry;
    logic [ENTRY_W-1:0] rdata;

    // Hold the request for the whole operation
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    assign req_entry.key         = r_req.plate_key;
    assign req_entry.make_code   = r_req.make_code;
    assign req_entry.model_code  = r_req.model_code;
    assign req_entry.colour_code = r_req.colour_code;

    assign rd_entry = t_entry'(rdata);

    // Compare the entry read last cycle against the request
    assign hit.key_hit  = (rd_entry.key == req_entry.key);
    assign hit.full_hit = (rd_entry == req_entry);

    // Write either the new record or the relocated last record
    assign wr_entry = mem.wsel_last ? rd_entry : req_entry;

    ukrt_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (wr_entry),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    ukrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (r_req.cmd),
        .i_hit   (hit),
        .o_mem   (mem),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("response issued while still busy");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_rsp.entry_count <= COUNT_W'(CAPACITY))
        else $error("record count beyond capacity");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.status != STAT_OK) |-> o_rsp.match_index == '0)
        else $error("match index set on a failed request");

endmodule
